[rtl/token_noise_reducer_macros.svh]
// assertion macros shared by the noise reducer modules
`ifndef TOKEN_NOISE_REDUCER_MACROS_SVH
`define TOKEN_NOISE_REDUCER_MACROS_SVH

// same-cycle implication
`define TNR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TNR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tnr_pkg.sv]
// types, constants and codes of the token noise reducer
package tnr_pkg;

  localparam int RefWidth      = 16;
  localparam int ProbWidth     = 16;
  localparam int CountWidth    = 16;
  localparam int LimitWidth    = 4;
  localparam int GapWidth      = 2;
  localparam int InDataWidth   = ((RefWidth + ProbWidth + 7) / 8) * 8;
  localparam int OutDataWidth  = ((RefWidth + 2 * CountWidth + 7) / 8) * 8;
  localparam int OutUserWidth  = 3;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;
  localparam int QueueDepth    = 2;
  localparam int QueuePtrWidth = $clog2(QueueDepth);
  localparam int QueueCntWidth = $clog2(QueueDepth + 1);

  typedef logic [RefWidth-1:0]   ref_t;
  typedef logic [ProbWidth-1:0]  prob_t;
  typedef logic [CountWidth-1:0] count_t;
  typedef logic [LimitWidth-1:0] limit_t;

  // register indexes
  localparam logic [CfgIndexWidth-1:0] REG_STRONG_LOW_CUT  = CfgIndexWidth'(0);
  localparam logic [CfgIndexWidth-1:0] REG_STRONG_HIGH_CUT = CfgIndexWidth'(1);
  localparam logic [CfgIndexWidth-1:0] REG_NEUTRAL_FLOOR   = CfgIndexWidth'(2);
  localparam logic [CfgIndexWidth-1:0] REG_NEUTRAL_CEILING = CfgIndexWidth'(3);
  localparam logic [CfgIndexWidth-1:0] REG_END_LOW_MARK    = CfgIndexWidth'(4);
  localparam logic [CfgIndexWidth-1:0] REG_END_HIGH_MARK   = CfgIndexWidth'(5);
  localparam logic [CfgIndexWidth-1:0] REG_SHORT_DUB_LIMIT = CfgIndexWidth'(6);

  // register reset values, Q0.16 probabilities; the short dub limit is a plain count
  localparam prob_t  STRONG_LOW_CUT_RST  = prob_t'(19661);
  localparam prob_t  STRONG_HIGH_CUT_RST = prob_t'(58982);
  localparam prob_t  NEUTRAL_FLOOR_RST   = prob_t'(26214);
  localparam prob_t  NEUTRAL_CEILING_RST = prob_t'(39322);
  localparam prob_t  END_LOW_MARK_RST    = prob_t'(16384);
  localparam prob_t  END_HIGH_MARK_RST   = prob_t'(52429);
  localparam limit_t SHORT_DUB_LIMIT_RST = limit_t'(4);

  typedef enum logic [1:0] {
    ACT_ELIMINATED = 2'd0,
    ACT_CLEAN      = 2'd1,
    ACT_RESTORED   = 2'd2
  } action_t;

  typedef struct packed {
    prob_t  strong_low_cut;
    prob_t  strong_high_cut;
    prob_t  neutral_floor;
    prob_t  neutral_ceiling;
    prob_t  end_low_mark;
    prob_t  end_high_mark;
    limit_t short_dub_limit;
  } cfg_t;

  // one token to judge, already classified against the thresholds
  typedef struct packed {
    ref_t token_ref;
    logic is_header;
    logic is_low;
    logic is_high;
    logic self_neutral;
    logic next_neutral;
    logic end_high;
    logic end_low;
    logic next_end_low;
    logic message_done;
    logic last_of_run;
  } job_t;

  typedef struct packed {
    ref_t    target_ref;
    action_t action;
    count_t  eliminated_total;
    count_t  clean_total;
    logic    message_done;
    logic    last_of_run;
  } result_t;

endpackage

[rtl/tnr_front.sv]
// front end: takes tokens, holds the lookahead token and issues classified jobs
`include "token_noise_reducer_macros.svh"

module tnr_front import tnr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [InDataWidth-1:0] s_tdata,
  input  logic                   s_tuser,
  input  logic                   s_tlast,
  output logic                   push,
  output job_t                   push_job,
  input  logic                   q_full
);

  logic  hold_valid;
  ref_t  hold_ref;
  prob_t hold_prob;
  logic  hold_hdr;
  logic  hold_last;
  logic  pending_valid;
  ref_t  pending_ref;
  prob_t pending_prob;
  logic  pending_hdr;

  function automatic job_t classify(input ref_t ref_in, input prob_t prob,
                                    input logic hdr, input prob_t nprob,
                                    input cfg_t c, input logic done,
                                    input logic lor);
    job_t j;
    j.token_ref    = ref_in;
    j.is_header    = hdr;
    j.is_low       = prob <= c.strong_low_cut;
    j.is_high      = prob >= c.strong_high_cut;
    j.self_neutral = (prob >= c.neutral_floor) && (prob <= c.neutral_ceiling);
    j.next_neutral = (nprob >= c.neutral_floor) && (nprob <= c.neutral_ceiling);
    j.end_high     = prob >= c.end_high_mark;
    j.end_low      = prob <= c.end_low_mark;
    j.next_end_low = nprob <= c.end_low_mark;
    j.message_done = done;
    j.last_of_run  = lor;
    return j;
  endfunction

  assign s_tready = !hold_valid;

  // the pending token goes first, then the held token if it ends the message
  always_comb begin
    push     = 1'b0;
    push_job = classify(hold_ref, hold_prob, hold_hdr, hold_prob, cfg, 1'b1, 1'b1);
    if (hold_valid && !q_full) begin
      if (pending_valid) begin
        push     = 1'b1;
        push_job = classify(pending_ref, pending_prob, pending_hdr, hold_prob, cfg,
                            1'b0, !hold_last);
      end else if (hold_last) begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid    <= 1'b0;
      pending_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      hold_valid <= 1'b1;
      hold_ref   <= s_tdata[RefWidth-1:0];
      hold_prob  <= s_tdata[RefWidth +: ProbWidth];
      hold_hdr   <= s_tuser;
      hold_last  <= s_tlast;
    end else if (hold_valid && !q_full) begin
      if (pending_valid) begin
        pending_valid <= 1'b0;
      end else begin
        hold_valid <= 1'b0;
        if (!hold_last) begin
          pending_valid <= 1'b1;
          pending_ref   <= hold_ref;
          pending_prob  <= hold_prob;
          pending_hdr   <= hold_hdr;
        end
      end
    end
  end

  `TNR_ASSERT_NEXT(a_final_leaves_no_pending, clk, rst, push && push_job.message_done, !pending_valid, "token left pending after message end")

endmodule

[rtl/tnr_queue.sv]
// short job queue between front and back end
`include "token_noise_reducer_macros.svh"

module tnr_queue import tnr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic not_empty
);

  job_t                     entries [QueueDepth];
  logic [QueuePtrWidth-1:0] wr_ptr;
  logic [QueuePtrWidth-1:0] rd_ptr;
  logic [QueueCntWidth-1:0] count;

  assign full      = count == QueueCntWidth'(QueueDepth);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QueuePtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QueuePtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TNR_ASSERT_IMPL(a_no_push_when_full, clk, rst, push, !full, "push into full job queue")
  `TNR_ASSERT_IMPL(a_no_pop_when_empty, clk, rst, pop, not_empty, "pop from empty job queue")

endmodule

[rtl/tnr_back.sv]
// back end: judges tokens, tracks dub runs and emits restore and verdict results
`include "token_noise_reducer_macros.svh"

module tnr_back import tnr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  limit_t  short_dub_limit,
  input  logic    q_valid,
  input  job_t    q_head,
  output logic    pop,
  output logic    m_tvalid,
  input  logic    m_tready,
  output result_t res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESTORE,
    S_VERDICT
  } state_t;

  state_t                state;
  job_t                  cur;
  logic                  run_end;
  logic [1:0]            rest_left;
  logic                  before_valid;
  logic                  before_neutral;
  logic                  dub_active;
  limit_t                dub_count;
  logic [GapWidth-1:0]   dub_start_gap;
  ref_t                  recent_refs [2];
  count_t                elim_count;
  count_t                clean_count;

  logic                  slot_free;
  logic                  emit;
  logic                  head_end;
  logic                  head_undo;
  logic [1:0]            head_rest;
  logic                  rest_idx;
  logic                  da;
  logic                  elim;
  logic                  started;
  count_t                elim_next;
  count_t                clean_next;
  limit_t                dub_count_next;
  logic [GapWidth-1:0]   gap_next;

  assign slot_free = !m_tvalid || m_tready;
  assign emit      = ((state == S_RESTORE) || (state == S_VERDICT)) && slot_free;
  assign pop       = (state == S_IDLE) && q_valid;

  // run end and restore span are decided against the state before the verdict
  assign head_end  = dub_active &&
                     (q_head.end_high || (q_head.end_low && q_head.next_end_low));
  assign head_undo = head_end && (dub_count < short_dub_limit) && (dub_count > limit_t'(1));
  assign head_rest = !head_undo ? 2'd0 :
                     (dub_start_gap == '1) ? 2'd2 : 2'(dub_start_gap);
  // oldest first: two left reads the older entry
  assign rest_idx  = rest_left[1];

  assign da      = dub_active && !run_end;
  assign elim    = da || (!cur.is_header && (cur.is_low || cur.is_high) &&
                          ((before_valid && before_neutral) || cur.next_neutral));
  assign started = elim && cur.is_low;

  assign elim_next  = (elim_count == '1) ? elim_count : elim_count + 1'b1;
  assign clean_next = (clean_count == '1) ? clean_count : clean_count + 1'b1;

  always_comb begin
    dub_count_next = dub_count;
    if (started && !da) begin
      dub_count_next = limit_t'(1);
    end else if (da && dub_count != '1) begin
      dub_count_next = dub_count + 1'b1;
    end
    gap_next = dub_start_gap;
    if (started) begin
      gap_next = '0;
    end else if (dub_start_gap != '1) begin
      gap_next = dub_start_gap + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_tvalid       <= 1'b0;
      rest_left      <= 2'd0;
      run_end        <= 1'b0;
      before_valid   <= 1'b0;
      before_neutral <= 1'b0;
      dub_active     <= 1'b0;
      dub_count      <= '0;
      dub_start_gap  <= '0;
      recent_refs[0] <= '0;
      recent_refs[1] <= '0;
      elim_count     <= '0;
      clean_count    <= '0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur       <= q_head;
            run_end   <= head_end;
            rest_left <= head_rest;
            state     <= (head_rest != 2'd0) ? S_RESTORE : S_VERDICT;
          end
        end
        S_RESTORE: begin
          if (slot_free) begin
            res.target_ref       <= recent_refs[rest_idx];
            res.action           <= ACT_RESTORED;
            res.eliminated_total <= elim_count;
            res.clean_total      <= clean_count;
            res.message_done     <= 1'b0;
            res.last_of_run      <= 1'b0;
            rest_left            <= rest_left - 1'b1;
            if (rest_left == 2'd1) begin
              state <= S_VERDICT;
            end
          end
        end
        S_VERDICT: begin
          if (slot_free) begin
            res.target_ref       <= cur.token_ref;
            res.action           <= elim ? ACT_ELIMINATED : ACT_CLEAN;
            res.eliminated_total <= elim ? elim_next : elim_count;
            res.clean_total      <= elim ? clean_count : clean_next;
            res.message_done     <= cur.message_done;
            res.last_of_run      <= cur.last_of_run;
            state                <= S_IDLE;
            if (cur.message_done) begin
              before_valid   <= 1'b0;
              before_neutral <= 1'b0;
              dub_active     <= 1'b0;
              dub_count      <= '0;
              dub_start_gap  <= '0;
              recent_refs[0] <= '0;
              recent_refs[1] <= '0;
              elim_count     <= '0;
              clean_count    <= '0;
            end else begin
              before_valid   <= 1'b1;
              before_neutral <= cur.self_neutral;
              dub_active     <= da || started;
              dub_count      <= dub_count_next;
              dub_start_gap  <= gap_next;
              recent_refs[1] <= recent_refs[0];
              recent_refs[0] <= cur.token_ref;
              if (elim) begin
                elim_count <= elim_next;
              end else begin
                clean_count <= clean_next;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TNR_ASSERT_IMPL(a_restore_has_count, clk, rst, state == S_RESTORE, rest_left != 2'd0, "restore state with nothing left to restore")
  `TNR_ASSERT_IMPL(a_restore_in_run, clk, rst, state == S_RESTORE, dub_active, "restore outside a dub run")
  `TNR_ASSERT_NEXT(a_message_end_clears, clk, rst, state == S_VERDICT && slot_free && cur.message_done, elim_count == '0 && clean_count == '0 && !dub_active && !before_valid, "message state not cleared at message end")

endmodule

[rtl/token_noise_reducer.sv]
// top level of the token noise reducer: config registers, front, queue, back
//
//  channel   | direction | transfer content
//  ----------+-----------+----------------------------------------------------
//  s_*       | in        | tdata: token_ref, probability; tuser: is_header;
//            |           | tlast: message_end
//  m_*       | out       | tdata: target_ref, eliminated_total, clean_total;
//            |           | tuser: action, last_of_run; tlast: message_done
//  cfg_*     | in        | write enable, register index, 16-bit data
//
// a token passes these steps: the input holding register issues the pending job, then either
// issues its own job when it ends the message or parks the token as the lookahead, and the
// back-end sequencer picks up a job, sends one result per restore and then the verdict;
// at most one result leaves per cycle.
// reset is synchronous on rst; there is no clearing pass.
// a low m_tready holds the output register; the two-job queue lets the front end keep
// taking tokens while the back end waits.

module token_noise_reducer import tnr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [InDataWidth-1:0]   s_tdata,   // token_ref, probability
  input  logic                     s_tuser,   // is_header
  input  logic                     s_tlast,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OutDataWidth-1:0]  m_tdata,   // target_ref, eliminated_total, clean_total
  output logic [OutUserWidth-1:0]  m_tuser,   // action, last_of_run
  output logic                     m_tlast
);

  cfg_t    cfg;
  logic    push;
  job_t    push_job;
  logic    q_full;
  logic    pop;
  job_t    q_head;
  logic    q_valid;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strong_low_cut  <= STRONG_LOW_CUT_RST;
      cfg.strong_high_cut <= STRONG_HIGH_CUT_RST;
      cfg.neutral_floor   <= NEUTRAL_FLOOR_RST;
      cfg.neutral_ceiling <= NEUTRAL_CEILING_RST;
      cfg.end_low_mark    <= END_LOW_MARK_RST;
      cfg.end_high_mark   <= END_HIGH_MARK_RST;
      cfg.short_dub_limit <= SHORT_DUB_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRONG_LOW_CUT:  cfg.strong_low_cut  <= prob_t'(cfg_data);
        REG_STRONG_HIGH_CUT: cfg.strong_high_cut <= prob_t'(cfg_data);
        REG_NEUTRAL_FLOOR:   cfg.neutral_floor   <= prob_t'(cfg_data);
        REG_NEUTRAL_CEILING: cfg.neutral_ceiling <= prob_t'(cfg_data);
        REG_END_LOW_MARK:    cfg.end_low_mark    <= prob_t'(cfg_data);
        REG_END_HIGH_MARK:   cfg.end_high_mark   <= prob_t'(cfg_data);
        REG_SHORT_DUB_LIMIT: cfg.short_dub_limit <= cfg_data[LimitWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  tnr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  tnr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .head      (q_head),
    .not_empty (q_valid)
  );

  tnr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .short_dub_limit (cfg.short_dub_limit),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .pop             (pop),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .res             (res)
  );

  assign m_tdata = OutDataWidth'({res.clean_total, res.eliminated_total, res.target_ref});
  assign m_tuser = {res.last_of_run, res.action};
  assign m_tlast = res.message_done;

endmodule
